[sv/rcsm_pkg.sv]
// ----------------------------------------------------------------------------
// rcsm_pkg
// Shared types and constants of the relay contact state monitor.
// ----------------------------------------------------------------------------
package rcsm_pkg;

  // Report codes
  typedef logic [2:0] code_t;

  localparam code_t CODE_UNKNOWN = 3'd0;
  localparam code_t CODE_OPEN    = 3'd1;
  localparam code_t CODE_CLOSED  = 3'd2;
  localparam code_t CODE_ERROR   = 3'd3;
  localparam code_t CODE_FAILED  = 3'd4;
  localparam code_t CODE_NONE    = 3'd7;

  // Configuration register indexes
  typedef logic [0:0] cfg_index_t;

  localparam cfg_index_t REG_FILTER_GAIN  = 1'd0;
  localparam cfg_index_t REG_DECIDE_LEVEL = 1'd1;

  // Configuration register width and reset values
  localparam int CFG_W = 16;
  localparam logic [CFG_W-1:0] FILTER_GAIN_RST  = 16'd655;
  localparam logic [CFG_W-1:0] DECIDE_LEVEL_RST = 16'd58982;

  // Gain is a fraction of 2^16; the rounding bias makes the decay step a floor
  localparam int GAIN_FRAC = 16;
  localparam logic [GAIN_FRAC-1:0] ROUND_BIAS = 16'hFFFF;

  // Threshold is rescaled by taking the top bits of a zero-padded word
  localparam int THR_PAD = 32;
  localparam int THR_W   = CFG_W + THR_PAD;

endpackage

[sv/rcsm_if.sv]
// ----------------------------------------------------------------------------
// rcsm_if
// Valid/ready channels of the relay contact state monitor.
// ----------------------------------------------------------------------------
interface rcsm_in_if;
  logic valid;
  logic ready;
  logic open_contact_closed;
  logic closed_contact_closed;
  logic sink_ready;

  modport source (
    output valid, open_contact_closed, closed_contact_closed, sink_ready,
    input  ready
  );
  modport sink (
    input  valid, open_contact_closed, closed_contact_closed, sink_ready,
    output ready
  );
endinterface

interface rcsm_out_if;
  logic                 valid;
  logic                 ready;
  rcsm_pkg::code_t      relay_code;

  modport source (
    output valid, relay_code,
    input  ready
  );
  modport sink (
    input  valid, relay_code,
    output ready
  );
endinterface

[sv/rcsm_filter.sv]
// ----------------------------------------------------------------------------
// rcsm_filter
// One exponential filter step: move the level toward full scale or zero.
// ----------------------------------------------------------------------------
module rcsm_filter #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                         hit,
  input  logic [rcsm_pkg::CFG_W-1:0]   gain,
  input  logic [LEVEL_BITS-1:0]        level,
  output logic [LEVEL_BITS-1:0]        level_nxt
);

  localparam int PW = LEVEL_BITS + rcsm_pkg::CFG_W + 1;

  logic [LEVEL_BITS-1:0] diff;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         sum;
  logic [LEVEL_BITS-1:0] step;

  always_comb begin
    // distance to full scale is the complement of the level
    diff = hit ? ~level : level;
    prod = PW'(gain) * PW'(diff);
    // round the decay step up so the level drops by floor of the signed step
    sum  = prod + (hit ? '0 : PW'(rcsm_pkg::ROUND_BIAS));
    step = sum[rcsm_pkg::GAIN_FRAC +: LEVEL_BITS];
    level_nxt = hit ? (level + step) : (level - step);
  end

endmodule

[sv/relay_contact_state_monitor_core.sv]
// ----------------------------------------------------------------------------
// relay_contact_state_monitor_core
// Filter relay contact samples and report changes of the contact class.
// ----------------------------------------------------------------------------
// Pipeline: the input register loads at the accept edge, and the filter update
//   and result register load when the word moves on, which a held result word
//   can delay.
// Throughput: one word per cycle; the only stall is a held result word.
// Reset (rst_n low, synchronous): filters go to one half, gain and threshold
//   to their defaults, nothing reported yet, both stages empty.
// ----------------------------------------------------------------------------
module relay_contact_state_monitor_core #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rcsm_in_if.sink                       in_word,
  rcsm_out_if.source                    out_word,
  input  logic                          cfg_we,
  input  rcsm_pkg::cfg_index_t          cfg_index,
  input  logic [rcsm_pkg::CFG_W-1:0]    cfg_data
);

  localparam logic [LEVEL_BITS-1:0] LEVEL_HALF = LEVEL_BITS'(1) << (LEVEL_BITS - 1);

  // Configuration registers
  logic [rcsm_pkg::CFG_W-1:0] filter_gain_r;
  logic [rcsm_pkg::CFG_W-1:0] decide_level_r;

  // Input stage
  logic s1_valid_r;
  logic s1_no_r;
  logic s1_nc_r;
  logic s1_sink_ready_r;

  // Filter levels and report memory
  logic [LEVEL_BITS-1:0] lvl_err_r, lvl_open_r, lvl_closed_r, lvl_unk_r, lvl_fail_r;
  logic [LEVEL_BITS-1:0] lvl_err_nxt, lvl_open_nxt, lvl_closed_nxt, lvl_unk_nxt;
  logic [LEVEL_BITS-1:0] lvl_fail_nxt, fail_up, fail_dn;
  rcsm_pkg::code_t       last_rep_r;

  // Result stage
  logic            out_valid_r;
  rcsm_pkg::code_t out_code_r;

  // Datapath
  logic [rcsm_pkg::THR_W-1:0] thr_wide;
  logic [LEVEL_BITS-1:0]      thr;
  logic eh, el, oh, ol, ch, cl, uh, ul, fail_hit;
  logic            have;
  rcsm_pkg::code_t code;
  logic            emit;

  // Handshake control
  logic stall;
  logic advance;
  logic in_fire;

  // Hold the result word while the sink refuses it; otherwise let the pipe move
  assign stall   = out_valid_r && !out_word.ready;
  assign advance = s1_valid_r && !stall;
  assign in_word.ready = !s1_valid_r || !stall;
  assign in_fire = in_word.valid && in_word.ready;

  assign out_word.valid      = out_valid_r;
  assign out_word.relay_code = out_code_r;

  // The four contact filters, each steered by its own contact combination
  rcsm_filter #(.LEVEL_BITS(LEVEL_BITS)) u_flt_err (
    .hit(s1_no_r && s1_nc_r), .gain(filter_gain_r),
    .level(lvl_err_r), .level_nxt(lvl_err_nxt)
  );
  rcsm_filter #(.LEVEL_BITS(LEVEL_BITS)) u_flt_open (
    .hit(s1_no_r && !s1_nc_r), .gain(filter_gain_r),
    .level(lvl_open_r), .level_nxt(lvl_open_nxt)
  );
  rcsm_filter #(.LEVEL_BITS(LEVEL_BITS)) u_flt_closed (
    .hit(!s1_no_r && s1_nc_r), .gain(filter_gain_r),
    .level(lvl_closed_r), .level_nxt(lvl_closed_nxt)
  );
  rcsm_filter #(.LEVEL_BITS(LEVEL_BITS)) u_flt_unk (
    .hit(!s1_no_r && !s1_nc_r), .gain(filter_gain_r),
    .level(lvl_unk_r), .level_nxt(lvl_unk_nxt)
  );

  // The failed filter's direction depends on the new levels: compute both
  // candidates from the old level in parallel and select afterwards
  rcsm_filter #(.LEVEL_BITS(LEVEL_BITS)) u_flt_fail_up (
    .hit(1'b1), .gain(filter_gain_r), .level(lvl_fail_r), .level_nxt(fail_up)
  );
  rcsm_filter #(.LEVEL_BITS(LEVEL_BITS)) u_flt_fail_dn (
    .hit(1'b0), .gain(filter_gain_r), .level(lvl_fail_r), .level_nxt(fail_dn)
  );

  always_comb begin
    // Rescale the threshold: the top LEVEL_BITS of the zero-padded word shift
    // left for wide levels and truncate for narrow ones
    thr_wide = {decide_level_r, rcsm_pkg::THR_PAD'(0)};
    thr      = thr_wide[rcsm_pkg::THR_W-1 -: LEVEL_BITS];

    // Strict compares: a level equal to the threshold is neither
    eh = lvl_err_nxt > thr;    el = lvl_err_nxt < thr;
    oh = lvl_open_nxt > thr;   ol = lvl_open_nxt < thr;
    ch = lvl_closed_nxt > thr; cl = lvl_closed_nxt < thr;
    uh = lvl_unk_nxt > thr;    ul = lvl_unk_nxt < thr;

    fail_hit     = el && ol && cl && ul;
    lvl_fail_nxt = fail_hit ? fail_up : fail_dn;

    // Exactly one combination above and the rest below picks a class;
    // otherwise fall back to failed if that filter is above
    have = 1'b1;
    code = rcsm_pkg::CODE_UNKNOWN;
    priority if (eh && ol && cl && ul) begin
      code = rcsm_pkg::CODE_ERROR;
    end else if (el && oh && cl && ul) begin
      code = rcsm_pkg::CODE_OPEN;
    end else if (el && ol && ch && ul) begin
      code = rcsm_pkg::CODE_CLOSED;
    end else if (el && ol && cl && uh) begin
      code = rcsm_pkg::CODE_UNKNOWN;
    end else if (lvl_fail_nxt > thr) begin
      code = rcsm_pkg::CODE_FAILED;
    end else begin
      have = 1'b0;
    end

    // Report only a change, and only when the word's sink_ready flag gave room
    emit = have && (code != last_rep_r) && s1_sink_ready_r;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_gain_r  <= rcsm_pkg::FILTER_GAIN_RST;
      decide_level_r <= rcsm_pkg::DECIDE_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcsm_pkg::REG_FILTER_GAIN:  filter_gain_r  <= cfg_data;
        rcsm_pkg::REG_DECIDE_LEVEL: decide_level_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage: load on accept, drain when the word moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_no_r         <= in_word.open_contact_closed;
      s1_nc_r         <= in_word.closed_contact_closed;
      s1_sink_ready_r <= in_word.sink_ready;
    end
  end

  // Filter state and report memory advance once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_err_r    <= LEVEL_HALF;
      lvl_open_r   <= LEVEL_HALF;
      lvl_closed_r <= LEVEL_HALF;
      lvl_unk_r    <= LEVEL_HALF;
      lvl_fail_r   <= LEVEL_HALF;
      last_rep_r   <= rcsm_pkg::CODE_NONE;
    end else if (advance) begin
      lvl_err_r    <= lvl_err_nxt;
      lvl_open_r   <= lvl_open_nxt;
      lvl_closed_r <= lvl_closed_nxt;
      lvl_unk_r    <= lvl_unk_nxt;
      lvl_fail_r   <= lvl_fail_nxt;
      if (emit) begin
        last_rep_r <= code;
      end
    end
  end

  // Result stage: refill whenever the held word is gone or taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!stall) begin
      out_valid_r <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_code_r <= code;
    end
  end

endmodule

[sv/rcsm_checker.sv]
// ----------------------------------------------------------------------------
// rcsm_checker
// Port-level checks of the relay contact state monitor.
// ----------------------------------------------------------------------------
module rcsm_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input rcsm_pkg::code_t relay_code
);

  rcsm_pkg::code_t last_del_r;

  // Track the last delivered code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_del_r <= rcsm_pkg::CODE_NONE;
    end else if (out_valid && out_ready) begin
      last_del_r <= relay_code;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(relay_code))
    else $error("stalled result word dropped or changed");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> relay_code <= rcsm_pkg::CODE_FAILED)
    else $error("relay code out of range");

  a_change_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> relay_code != last_del_r)
    else $error("same class reported twice in a row");

endmodule

bind relay_contact_state_monitor_core rcsm_checker u_rcsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_word.valid),
  .out_ready  (out_word.ready),
  .relay_code (out_word.relay_code)
);
